// ===== rtl/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, constants and the font table of the glyph rectangle generator.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 8;
  localparam int DIGIT_BASE   = 27;
  localparam int NUM_GLYPHS   = 37;

  localparam int SLOT_W  = 6;
  localparam int COL_W   = 3;
  localparam int ROW_W   = 3;
  localparam int GWORD_W = 40;  // five column bytes, column 0 in the low byte

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FG_COLOR = 2'd0,
    REG_BG_COLOR = 2'd1,
    REG_SCALE    = 2'd2
  } cfg_reg_t;

  // Start request from the input side to the rectangle sequencer
  typedef struct packed {
    logic       start;
    logic [7:0] x0;
    logic [7:0] y0;
  } start_req_t;

  function automatic logic [SLOT_W-1:0] glyph_slot(input logic [7:0] code);
    logic [SLOT_W-1:0] slot;
    slot = '0;
    if (code >= 8'h41 && code <= 8'h5A) begin
      slot = SLOT_W'(code - 8'h41 + 8'd1);
    end else if (code >= 8'h30 && code <= 8'h39) begin
      slot = SLOT_W'(code - 8'h30 + 8'(DIGIT_BASE));
    end
    return slot;
  endfunction

  // Column bitmaps, bit 0 of each byte is the top row
  function automatic logic [GWORD_W-1:0] glyph_word(input logic [SLOT_W-1:0] slot);
    logic [GWORD_W-1:0] w;
    case (slot)
      6'd1:    w = 40'h7E_11_11_11_7E;
      6'd2:    w = 40'h36_49_49_49_7F;
      6'd3:    w = 40'h22_41_41_41_3E;
      6'd4:    w = 40'h1C_22_41_41_7F;
      6'd5:    w = 40'h41_49_49_49_7F;
      6'd6:    w = 40'h01_09_09_09_7F;
      6'd7:    w = 40'h7A_49_49_41_3E;
      6'd8:    w = 40'h7F_08_08_08_7F;
      6'd9:    w = 40'h00_41_7F_41_00;
      6'd10:   w = 40'h01_3F_41_40_20;
      6'd11:   w = 40'h41_22_14_08_7F;
      6'd12:   w = 40'h40_40_40_40_7F;
      6'd13:   w = 40'h7F_02_0C_02_7F;
      6'd14:   w = 40'h7F_10_08_04_7F;
      6'd15:   w = 40'h3E_41_41_41_3E;
      6'd16:   w = 40'h06_09_09_09_7F;
      6'd17:   w = 40'h5E_21_51_41_3E;
      6'd18:   w = 40'h46_29_19_09_7F;
      6'd19:   w = 40'h31_49_49_49_46;
      6'd20:   w = 40'h01_01_7F_01_01;
      6'd21:   w = 40'h3F_40_40_40_3F;
      6'd22:   w = 40'h1F_20_40_20_1F;
      6'd23:   w = 40'h3F_40_38_40_3F;
      6'd24:   w = 40'h63_14_08_14_63;
      6'd25:   w = 40'h07_08_70_08_07;
      6'd26:   w = 40'h43_45_49_51_61;
      6'd27:   w = 40'h3E_45_49_51_3E;
      6'd28:   w = 40'h00_40_7F_42_00;
      6'd29:   w = 40'h46_49_51_61_42;
      6'd30:   w = 40'h31_4B_45_41_21;
      6'd31:   w = 40'h10_7F_12_14_18;
      6'd32:   w = 40'h39_45_45_45_27;
      6'd33:   w = 40'h30_49_49_4A_3C;
      6'd34:   w = 40'h03_05_09_71_01;
      6'd35:   w = 40'h36_49_49_49_36;
      6'd36:   w = 40'h1E_29_49_49_06;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/sgr_font_rom.sv =====
// ----------------------------------------------------------------------------
// sgr_font_rom
// Font memory: one glyph (all five columns) per entry, registered read.
// ----------------------------------------------------------------------------
module sgr_font_rom import sgr_pkg::*; (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [SLOT_W-1:0]  rd_slot,
  output logic [GWORD_W-1:0] rd_data
);

  logic [GWORD_W-1:0] rd_data_r;

  // hold the word for the whole glyph; only a new request reloads it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= glyph_word(rd_slot);
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sgr_rect_gen.sv =====
// ----------------------------------------------------------------------------
// sgr_rect_gen
// Walks the glyph cells column-major, then the gap column, one rectangle per
// cycle into the output register while that register is free to take it.
// ----------------------------------------------------------------------------
module sgr_rect_gen import sgr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  start_req_t         req,
  input  logic [GWORD_W-1:0] glyph_q,
  input  logic [15:0]        fg_color,
  input  logic [15:0]        bg_color,
  input  logic [4:0]         scale,
  output logic               take_ok,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,  // rect_x, rect_y, rect_w, rect_h, rect_color, pad
  output logic               out_tlast   // last_rect
);

  logic             busy_r;
  logic             gap_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [7:0]       cx_r;
  logic [7:0]       cy_r;
  logic [7:0]       y0_r;

  logic             out_valid_r;
  logic [7:0]       rx_r;
  logic [7:0]       ry_r;
  logic [4:0]       rw_r;
  logic [7:0]       rh_r;
  logic [15:0]      rc_r;
  logic             rl_r;

  logic             out_free;
  logic             bit_set;
  logic [7:0]       scale8;

  assign out_free = !out_valid_r || out_tready;
  assign take_ok  = !busy_r || (gap_r && out_free);
  assign bit_set  = glyph_q[{col_r, row_r}];
  assign scale8   = {3'b000, scale};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      gap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (busy_r && out_free) begin
        out_valid_r <= 1'b1;
        rx_r        <= cx_r;
        rw_r        <= scale;
        if (gap_r) begin
          ry_r   <= y0_r;
          rh_r   <= 8'({scale, 3'b000});
          rc_r   <= bg_color;
          rl_r   <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          ry_r <= cy_r;
          rh_r <= scale8;
          rc_r <= bit_set ? fg_color : bg_color;
          rl_r <= 1'b0;
          // advance down the column, then step to the next column
          if (row_r == LAST_ROW) begin
            row_r <= '0;
            col_r <= col_r + COL_W'(1);
            cx_r  <= cx_r + scale8;
            cy_r  <= y0_r;
            if (col_r == LAST_COL) begin
              gap_r <= 1'b1;
            end
          end else begin
            row_r <= row_r + ROW_W'(1);
            cy_r  <= cy_r + scale8;
          end
        end
      end
      if (req.start) begin
        busy_r <= 1'b1;
        gap_r  <= 1'b0;
        col_r  <= '0;
        row_r  <= '0;
        cx_r   <= req.x0;
        cy_r   <= req.y0;
        y0_r   <= req.y0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, rc_r, rh_r, rw_r, ry_r, rx_r};
  assign out_tlast  = rl_r;

endmodule

// ===== rtl/scaled_glyph_rect_generator_top.sv =====
// ----------------------------------------------------------------------------
// scaled_glyph_rect_generator_top
// Character code in, 41 fill-rectangle requests out.
// ----------------------------------------------------------------------------
// Each accepted character yields 41 rectangle requests, one per cycle while
// the output side keeps taking them: 40 font cells of the 5x8 glyph
// (column-major, top row first) followed by a background gap column flagged
// with tlast. The rate is set by the rectangle sequencer, which emits one
// rectangle per cycle while its output register is free; the next character
// is taken in the cycle the gap column goes out, and its font word is read
// from the font memory in that same cycle, so characters run with no bubble.
// The sequencer registers the start, then the first request goes into the output register once it is free.
// Unsupported codes draw as a space. Coordinates wrap modulo 256. Write the
// color and scale registers only while no character is in flight.
// ----------------------------------------------------------------------------
module scaled_glyph_rect_generator_top import sgr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // start_x, start_y, char_code
  input  logic        in_tuser,   // place
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // rect_x, rect_y, rect_w, rect_h, rect_color, pad
  output logic        out_tlast   // last_rect
);

  logic [15:0]        fg_r;
  logic [15:0]        bg_r;
  logic [4:0]         scale_r;
  logic [7:0]         cursor_x_r;
  logic [7:0]         cursor_y_r;

  logic               take_ok;
  logic               accept;
  logic [7:0]         base_x;
  logic [7:0]         base_y;
  logic [7:0]         advance;
  logic [GWORD_W-1:0] glyph_q;
  start_req_t         req;

  assign in_tready = take_ok;
  assign accept    = in_tvalid && take_ok;
  assign base_x    = in_tuser ? in_tdata[7:0]  : cursor_x_r;
  assign base_y    = in_tuser ? in_tdata[15:8] : cursor_y_r;
  assign advance   = 8'({3'b000, scale_r, 2'b00} + {4'b0000, scale_r, 1'b0});

  assign req.start = accept;
  assign req.x0    = base_x;
  assign req.y0    = base_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r       <= 16'hFFFF;
      bg_r       <= 16'h0000;
      scale_r    <= 5'd1;
      cursor_x_r <= 8'd0;
      cursor_y_r <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_FG_COLOR: fg_r    <= cfg_wdata;
          REG_BG_COLOR: bg_r    <= cfg_wdata;
          REG_SCALE:    scale_r <= cfg_wdata[4:0];
          default:      ;
        endcase
      end
      if (accept) begin
        cursor_x_r <= base_x + advance;
        cursor_y_r <= base_y;
      end
    end
  end

  sgr_font_rom u_font_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_slot (glyph_slot(in_tdata[23:16])),
    .rd_data (glyph_q)
  );

  sgr_rect_gen u_rect_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .glyph_q    (glyph_q),
    .fg_color   (fg_r),
    .bg_color   (bg_r),
    .scale      (scale_r),
    .take_ok    (take_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/scaled_glyph_rect_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_glyph_rect_generator_top_tb
// Self-checking bench for the character-to-rectangle generator.
// A directed set of characters covers the font edges, unsupported codes,
// placement, coordinate wrap and scale extremes. Randomized phases with new
// colors and scales follow. Every request is predicted by a local font and
// cursor model and is checked field by field against the rectangle stream.
// The bench idles the input side and stalls the output side at random.
// ----------------------------------------------------------------------------
module scaled_glyph_rect_generator_top_tb;
  import sgr_pkg::*;

  localparam int         CLK_HALF     = 6;
  localparam int         RESET_CYCLES = 12;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         DRAIN_CYCLES = 8;
  localparam logic [1:0] REG_SPARE    = 2'd3;  // no register behind this index
  localparam int         RAND_PHASES  = 6;
  localparam int         RAND_CHARS   = 23;

  typedef struct packed {
    logic       place;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] char_code;
  } char_req_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [4:0]  w;
    logic [7:0]  h;
    logic [15:0] color;
    logic        last;
  } rect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // start_x, start_y, char_code
  logic        in_tuser = 1'b0; // place
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // rect_x, rect_y, rect_w, rect_h, rect_color, pad
  logic        out_tlast;       // last_rect

  scaled_glyph_rect_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // Model state
  logic [15:0] fg_color = 16'hFFFF;
  logic [15:0] bg_color = 16'h0000;
  logic [4:0]  dot_scale = 5'd1;
  logic [7:0]  cur_x = '0;
  logic [7:0]  cur_y = '0;

  char_req_t pending_chars[$];
  rect_t     rect_q[$];

  logic in_fire = 1'b0;
  int   errors = 0;
  int   chars_taken = 0;
  int   chars_placed = 0;
  int   rects_checked = 0;
  int   reg_writes = 0;
  int   idle_cycles = 0;
  int   burst_left = 4;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  int   stall_left = 0;

  function automatic int font_slot(input logic [7:0] code);
    if (code >= "A" && code <= "Z") return int'(code - "A") + 1;
    if (code >= "0" && code <= "9") return int'(code - "0") + DIGIT_BASE;
    return 0;
  endfunction

  // Column bytes listed left to right; bit 0 is the top row
  function automatic logic [7:0] font_column(input int slot, input int col);
    logic [0:4][7:0] cols;
    case (slot)
      1:  cols = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      2:  cols = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      3:  cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      4:  cols = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      5:  cols = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      6:  cols = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      7:  cols = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      8:  cols = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      9:  cols = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      10: cols = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      11: cols = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      12: cols = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      13: cols = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      14: cols = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      15: cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      16: cols = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      17: cols = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      18: cols = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      19: cols = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      20: cols = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      21: cols = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      22: cols = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      23: cols = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      24: cols = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      25: cols = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      26: cols = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      27: cols = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      28: cols = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      29: cols = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      30: cols = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      31: cols = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      32: cols = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      33: cols = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      34: cols = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      35: cols = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      36: cols = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      default: cols = '0;
    endcase
    if (col < 0 || col > 4) return 8'h00;
    return cols[col];
  endfunction

  task automatic predict_rects(input char_req_t req);
    int         slot;
    logic [7:0] x0;
    logic [7:0] y0;
    logic [7:0] col_bits;
    rect_t      r;
    slot = font_slot(req.char_code);
    if (req.place) begin
      cur_x = req.start_x;
      cur_y = req.start_y;
    end
    x0 = cur_x;
    y0 = cur_y;
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      col_bits = font_column(slot, c);
      for (int rw = 0; rw < GLYPH_HEIGHT; rw++) begin
        r.x     = x0 + 8'(c * dot_scale);
        r.y     = y0 + 8'(rw * dot_scale);
        r.w     = dot_scale;
        r.h     = 8'(dot_scale);
        r.color = (rw < 8 && col_bits[rw % 8]) ? fg_color : bg_color;
        r.last  = 1'b0;
        rect_q.push_back(r);
      end
    end
    // Gap column closes the character
    r.x     = x0 + 8'(GLYPH_WIDTH * dot_scale);
    r.y     = y0;
    r.w     = dot_scale;
    r.h     = 8'(GLYPH_HEIGHT * dot_scale);
    r.color = bg_color;
    r.last  = 1'b1;
    rect_q.push_back(r);
    cur_x = x0 + 8'((GLYPH_WIDTH + 1) * dot_scale);
  endtask

  function automatic void compare_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin : monitor
    rect_t exp_r;
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_FG_COLOR: fg_color = cfg_wdata;
          REG_BG_COLOR: bg_color = cfg_wdata;
          REG_SCALE:    dot_scale = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_rects({in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]});
        chars_taken++;
        if (in_tuser) chars_placed++;
      end
      if (out_tvalid && out_tready) begin
        if (rect_q.size() == 0) begin
          $error("unexpected rectangle request: tdata %h tlast %b", out_tdata, out_tlast);
          errors++;
        end else begin
          exp_r = rect_q.pop_front();
          compare_field("rect_x", 16'(exp_r.x), 16'(out_tdata[7:0]));
          compare_field("rect_y", 16'(exp_r.y), 16'(out_tdata[15:8]));
          compare_field("rect_w", 16'(exp_r.w), 16'(out_tdata[20:16]));
          compare_field("rect_h", 16'(exp_r.h), 16'(out_tdata[28:21]));
          compare_field("rect_color", exp_r.color, out_tdata[44:29]);
          compare_field("last_rect", 16'(exp_r.last), 16'(out_tlast));
          rects_checked++;
        end
      end
    end
  end

  // Input side: bursts of requests separated by random gaps
  always @(negedge clk) begin : driver
    logic      nxt_valid;
    char_req_t nxt;
    nxt_valid = in_tvalid;
    nxt = {in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
    if (rst_n) begin
      if (in_fire) begin
        void'(pending_chars.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 6);
        end
      end
      // hold a request that has not been taken yet
      if (!(in_tvalid && !in_fire)) begin
        if (gap_left > 0) begin
          gap_left--;
          nxt_valid = 1'b0;
        end else if (pending_chars.size() != 0) begin
          nxt_valid = 1'b1;
          nxt = pending_chars[0];
        end else begin
          nxt_valid = 1'b0;
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tuser  <= nxt.place;
    in_tdata  <= {nxt.char_code, nxt.start_y, nxt.start_x};
  end

  // Output side: switch between always ready, scattered stalls and stall runs
  always @(negedge clk) begin : receiver
    logic rdy;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          rdy = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(0, 4);
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
        end
      end
    endcase
    out_tready <= rdy;
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_char(input logic place, input logic [7:0] sx, input logic [7:0] sy,
                           input logic [7:0] code);
    pending_chars.push_back({place, sx, sy, code});
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
  endtask

  task automatic wait_idle();
    while (pending_chars.size() != 0 || rect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] random_code();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 8'("A" + $urandom_range(0, 25));
    if (sel < 6) return 8'("0" + $urandom_range(0, 9));
    if (sel == 6) return " ";
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int sel;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset colors and scale: font edges, unsupported codes, placement, wrap
    push_char(1'b1, 8'd0, 8'd0, "A");
    push_char(1'b0, 8'hAA, 8'h55, "Z");
    push_char(1'b0, 8'h00, 8'h00, "0");
    push_char(1'b0, 8'hFF, 8'hFF, "9");
    push_char(1'b0, 8'h00, 8'h00, " ");
    push_char(1'b0, 8'h12, 8'h34, 8'h00);
    push_char(1'b0, 8'h00, 8'h00, 8'hFF);
    push_char(1'b0, 8'h00, 8'h00, "@");
    push_char(1'b0, 8'h00, 8'h00, "[");
    push_char(1'b0, 8'h00, 8'h00, "/");
    push_char(1'b0, 8'h00, 8'h00, ":");
    push_char(1'b0, 8'h00, 8'h00, "a");
    push_char(1'b1, 8'd255, 8'd255, "M");
    push_char(1'b1, 8'd250, 8'd3, "8");
    wait_idle();

    // Largest nominal scale with inverted colors
    write_reg(REG_FG_COLOR, 16'h0000);
    write_reg(REG_BG_COLOR, 16'hFFFF);
    write_reg(REG_SCALE, 16'd16);
    push_char(1'b1, 8'd200, 8'd240, "W");
    push_char(1'b0, 8'h00, 8'h00, "K");
    push_char(1'b0, 8'h00, 8'h00, "5");
    wait_idle();

    // Zero scale: empty rectangles, cursor stays put; spare index ignored
    write_reg(REG_SCALE, 16'd0);
    write_reg(REG_SPARE, 16'h1234);
    write_reg(REG_FG_COLOR, 16'hA5A5);
    write_reg(REG_BG_COLOR, 16'h5A5A);
    push_char(1'b1, 8'd10, 8'd20, "B");
    push_char(1'b0, 8'h00, 8'h00, "B");
    wait_idle();

    // Scales beyond the nominal range
    write_reg(REG_SCALE, 16'd31);
    push_char(1'b1, 8'd100, 8'd100, "X");
    push_char(1'b0, 8'h00, 8'h00, "Q");
    wait_idle();
    write_reg(REG_SCALE, 16'hFFF1);
    push_char(1'b1, 8'd0, 8'd128, "R");
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(REG_FG_COLOR, 16'($urandom));
      write_reg(REG_BG_COLOR, 16'($urandom));
      sel = $urandom_range(0, 9);
      if (sel < 7) write_reg(REG_SCALE, 16'($urandom_range(1, 16)));
      else if (sel == 7) write_reg(REG_SCALE, ($urandom_range(0, 1) != 0) ? 16'd1 : 16'd16);
      else if (sel == 8) write_reg(REG_SCALE, 16'd0);
      else write_reg(REG_SCALE, 16'($urandom_range(17, 31)));
      if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, 16'($urandom));
      for (int i = 0; i < RAND_CHARS; i++) begin
        push_char($urandom_range(0, 3) == 0, 8'($urandom), 8'($urandom), random_code());
      end
      wait_idle();
    end

    $display("Run covered %0d characters (%0d placed) and %0d rectangle requests,",
             chars_taken, chars_placed, rects_checked);
    $display("with %0d register writes across nominal, zero and oversized scales.",
             reg_writes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
